FILE: rtl/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and codes for the key chord detector: opcodes, report codes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kcd_pkg;

  // Input opcodes
  typedef enum logic [2:0] {
    OP_KEY_DOWN = 3'd0,
    OP_KEY_UP   = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_ADD_KEY  = 3'd3,
    OP_QUERY    = 3'd4
  } kcd_op_t;

  // Report kinds
  typedef enum logic [1:0] {
    EV_ACTIVATED   = 2'd0,
    EV_DEACTIVATED = 2'd1,
    EV_REPLY       = 2'd2
  } kcd_ev_t;

  // Query reply status
  typedef enum logic [1:0] {
    STAT_INACTIVE = 2'd0,
    STAT_ACTIVE   = 2'd1,
    STAT_UNREG    = 2'd2
  } kcd_stat_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_FLUSH
  } kcd_state_t;

  // Input and output transaction widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Most reports one input transaction can produce; later ones are dropped
  localparam int MAX_RESULTS = 16;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic scan_adv;  // move to next slot, read it
    logic commit;    // apply current slot's result
    logic flush;     // push pending report out as the final one
    logic add_wr;    // write back slot mask for add key
    logic use_slot;  // mask read address is the latched slot
  } kcd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_scan;    // offered item is an in-range key down or key up
    logic in_add;     // offered item is an in-range add key
    logic in_query;   // offered item is a query
    logic hit;        // current slot changes state and reports
    logic pend_valid; // a report is held back
    logic out_free;   // output register can take a transaction
    logic idx_last;   // scan index is at the last slot
  } kcd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/kcd_datapath.sv
// ----------------------------------------------------------------------------
// kcd_datapath
// Held-key bitmap, slot mask memory, valid/active bits, scan index, one
// held-back report and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_datapath #(
  parameter int NUM_SLOTS = 16,
  parameter int KEY_CODES = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [kcd_pkg::IN_TDATA_W-1:0]    in_data,
  input  wire kcd_pkg::kcd_cmd_t                 cmd,
  output kcd_pkg::kcd_sts_t                      sts,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [kcd_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tlast
);
  import kcd_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KEY_W  = $clog2(KEY_CODES);

  // Input field decode
  logic [2:0]        in_op;
  logic [7:0]        in_key;
  logic [3:0]        in_slot;
  logic              in_key_ok;
  logic              in_slot_ok;
  logic [KEY_W-1:0]  in_key_idx;
  logic [SLOT_W-1:0] in_slot_idx;
  kcd_stat_t         query_stat;

  // State
  logic [KEY_CODES-1:0] held;
  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] active;
  logic [KEY_CODES-1:0] mask_mem [NUM_SLOTS];
  logic [KEY_CODES-1:0] rd_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic [KEY_CODES-1:0] wr_data;

  // Latched item
  logic              down_q;
  logic [KEY_W-1:0]  key_idx_q;
  logic [SLOT_W-1:0] slot_idx_q;

  // Scan and reports
  logic [SLOT_W-1:0] idx;
  logic              hit;
  logic [4:0]        rep_cnt;
  logic              rep_room;
  logic              pend_valid;
  kcd_ev_t           pend_ev;
  logic [3:0]        pend_slot;
  kcd_stat_t         pend_stat;
  logic              out_valid;
  kcd_ev_t           out_ev;
  logic [3:0]        out_slot;
  kcd_stat_t         out_stat;
  logic              out_last;

  assign in_op       = in_data[2:0];
  assign in_key      = in_data[10:3];
  assign in_slot     = in_data[14:11];
  assign in_key_ok   = {1'b0, in_key} < 9'(KEY_CODES);
  assign in_slot_ok  = 7'(in_slot) < 7'(NUM_SLOTS);
  assign in_key_idx  = KEY_W'(in_key);
  assign in_slot_idx = SLOT_W'(in_slot);

  // Reports past the per-item limit still change state but are not sent
  assign rep_room = (rep_cnt != 5'(MAX_RESULTS));

  // Query reply status from the live table
  always_comb begin
    query_stat = STAT_UNREG;
    if (in_slot_ok && valid[in_slot_idx]) begin
      query_stat = active[in_slot_idx] ? STAT_ACTIVE : STAT_INACTIVE;
    end
  end

  // Mask read address: next slot while advancing, else current slot or target
  always_comb begin
    if (cmd.use_slot) begin
      rd_addr = slot_idx_q;
    end else if (cmd.scan_adv) begin
      rd_addr = idx + SLOT_W'(1);
    end else begin
      rd_addr = idx;
    end
  end

  // A slot that is not valid holds an all-zero set
  assign wr_data = (valid[slot_idx_q] ? rd_data : '0) | (KEY_CODES'(1) << key_idx_q);

  // Slot mask memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mask_mem[slot_idx_q] <= wr_data;
    end
    rd_data <= mask_mem[rd_addr];
  end

  // Per-slot decision on the slot read last cycle
  always_comb begin
    if (down_q) begin
      hit = valid[idx] && !active[idx] && ((rd_data & ~held) == '0);
    end else begin
      hit = active[idx] && rd_data[key_idx_q];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      valid      <= '0;
      active     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      rep_cnt    <= '0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        idx     <= '0;
        rep_cnt <= '0;
        unique case (in_op)
          OP_KEY_DOWN: if (in_key_ok) held[in_key_idx] <= 1'b1;
          OP_KEY_UP:   if (in_key_ok) held[in_key_idx] <= 1'b0;
          OP_CLEAR: begin
            if (in_slot_ok) begin
              valid[in_slot_idx]  <= 1'b0;
              active[in_slot_idx] <= 1'b0;
            end
          end
          OP_QUERY:    pend_valid <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.scan_adv) begin
        idx <= idx + SLOT_W'(1);
      end
      if (cmd.commit && hit) begin
        active[idx] <= down_q;
        if (rep_room) begin
          pend_valid <= 1'b1;
          rep_cnt    <= rep_cnt + 5'd1;
          if (pend_valid) begin
            out_valid <= 1'b1;
          end
        end
      end
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
      if (cmd.add_wr) begin
        valid[slot_idx_q]  <= 1'b1;
        active[slot_idx_q] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      down_q     <= (in_op == OP_KEY_DOWN);
      key_idx_q  <= in_key_idx;
      slot_idx_q <= in_slot_idx;
      pend_ev    <= EV_REPLY;
      pend_slot  <= in_slot;
      pend_stat  <= query_stat;
    end
    // a new hit pushes the held-back report out as a non-final one
    if (cmd.commit && hit && rep_room) begin
      if (pend_valid) begin
        out_ev   <= pend_ev;
        out_slot <= pend_slot;
        out_stat <= pend_stat;
        out_last <= 1'b0;
      end
      pend_ev   <= down_q ? EV_ACTIVATED : EV_DEACTIVATED;
      pend_slot <= 4'(idx);
      pend_stat <= STAT_INACTIVE;
    end
    if (cmd.flush) begin
      out_ev   <= pend_ev;
      out_slot <= pend_slot;
      out_stat <= pend_stat;
      out_last <= 1'b1;
    end
  end

  // Status to controller
  always_comb begin
    sts.in_scan    = ((in_op == OP_KEY_DOWN) || (in_op == OP_KEY_UP)) && in_key_ok;
    sts.in_add     = (in_op == OP_ADD_KEY) && in_key_ok && in_slot_ok;
    sts.in_query   = (in_op == OP_QUERY);
    sts.hit        = hit && rep_room;
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || m_tready;
    sts.idx_last   = (idx == SLOT_W'(NUM_SLOTS - 1));
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_stat, out_slot, out_ev};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

FILE: rtl/kcd_ctrl.sv
// ----------------------------------------------------------------------------
// kcd_ctrl
// Sequencer: takes one item, runs the slot scan or the add-key
// read-modify-write, and flushes the final report.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire kcd_pkg::kcd_sts_t   sts,
  output kcd_pkg::kcd_cmd_t        cmd
);
  import kcd_pkg::*;

  kcd_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          priority if (sts.in_scan)  state_next = ST_SCAN_RD;
          else if (sts.in_add)       state_next = ST_ADD_RD;
          else if (sts.in_query)     state_next = ST_FLUSH;
          else                       state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        // a hit needs room for the held-back report
        if (!sts.hit || !sts.pend_valid || sts.out_free) begin
          cmd.commit = 1'b1;
          if (sts.idx_last) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end
      end
      ST_ADD_RD: begin
        cmd.use_slot = 1'b1;
        state_next   = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.use_slot = 1'b1;
        cmd.add_wr   = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/key_chord_detector.sv
// ----------------------------------------------------------------------------
// key_chord_detector
// Hotkey chord matcher: held-key bitmap plus a table of slot key sets;
// reports activations on key down, deactivations on key up, query replies.
// ----------------------------------------------------------------------------
//  channel  | dir | fields (tdata low bit up)                  | side band
//  ---------+-----+--------------------------------------------+-------------
//  s_axis   | in  | opcode[2:0] key_code[10:3] slot[14:11] 0    | -
//  m_axis   | out | event_res[1:0] slot_out[5:2] status[7:6]    | tlast = last
//
//  Key down / key up: a scan of the slot table with one slot mask memory
//  read per cycle while the output does not stall, then a flush of the final report.
//  Add key: read-modify-write on the mask memory.
//  Clear and unused opcodes finish in the idle state; a query passes through the flush state.
//  Reset clears held keys, valid and active bits; masks of invalid slots
//  read as empty, so the mask memory needs no clearing pass.
//  A stalled output holds the scan at the next hit; input waits meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module key_chord_detector #(
  parameter int NUM_SLOTS = 16,
  parameter int KEY_CODES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [kcd_pkg::IN_TDATA_W-1:0] s_tdata,  // opcode, key_code, slot
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [kcd_pkg::OUT_TDATA_W-1:0]     m_tdata,  // event_res, slot_out, status
  output logic                                m_tlast
);
  import kcd_pkg::*;

  kcd_cmd_t cmd;
  kcd_sts_t sts;

  kcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kcd_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_CODES (KEY_CODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/kcd_checker.sv
// ----------------------------------------------------------------------------
// kcd_checker
// Port-level checks on the key chord detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [kcd_pkg::IN_TDATA_W-1:0] s_tdata,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [kcd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tlast
);
  import kcd_pkg::*;

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Only activation, deactivation and reply codes appear
  a_ev_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("bad event code");

  // Status is zero outside query replies
  a_stat_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != EV_REPLY |-> m_tdata[7:6] == STAT_INACTIVE)
    else $error("status set on a key report");

  // A query reply is always the final transaction of its item
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == EV_REPLY |-> m_tlast)
    else $error("query reply without last");

  // Input is held off while a query reply is produced
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[2:0] == OP_QUERY |=> !s_tready)
    else $error("input taken during query reply");

endmodule

bind key_chord_detector kcd_checker u_kcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: sim/tb_key_chord_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_chord_detector
// Self-checking bench for the hotkey chord matcher. A short table of directed
// commands covers the empty table, the extreme key codes and slots, the
// reserved opcodes, repeated presses and stray releases. After it come random
// chord sequences, all-slot bursts and loose commands. Every accepted command
// is run through a behavioral copy of the slot table. Each report is checked
// in order against the predicted reports; typed directed rows give their own.
// ----------------------------------------------------------------------------
module tb_key_chord_detector;
  import kcd_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int KEY_CODES   = 256;
  localparam int RAND_CMDS   = 340;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  // opcodes the block ignores
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    kcd_ev_t    ev;
    logic [3:0] slot;
    kcd_stat_t  stat;
    logic       last;
  } report_t;

  // one command; typed rows carry their own expected reply
  typedef struct {
    logic [2:0] op;
    logic [7:0] key;
    logic [3:0] slot;
    bit         typed;
    bit         has_reply;
    kcd_stat_t  stat;
  } cmd_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // shadow of the slot table
  logic [KEY_CODES-1:0] keys_down;
  logic [KEY_CODES-1:0] chord_mask [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_used;
  logic [NUM_SLOTS-1:0] slot_live;

  report_t chord_batch [$];
  report_t pending_reports [$];

  logic [7:0] key_pool [8];
  bit         calm = 1'b0;
  int         errors = 0;
  int         cmds_sent = 0;
  int         n_act = 0;
  int         n_deact = 0;
  int         n_reply = 0;
  int         cycles = 0;

  cmd_row_t directed [24] = '{
    '{OP_QUERY,    8'd0,   4'd0,  1'b1, 1'b1, STAT_UNREG},
    '{OP_QUERY,    8'd255, 4'd15, 1'b1, 1'b1, STAT_UNREG},
    '{OP_RSVD5,    8'd255, 4'd15, 1'b1, 1'b0, STAT_INACTIVE},
    '{OP_RSVD7,    8'd0,   4'd0,  1'b1, 1'b0, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd0,   4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_KEY_UP,   8'd255, 4'd15, 1'b0, 1'b0, STAT_INACTIVE},
    '{OP_ADD_KEY,  8'd0,   4'd0,  1'b1, 1'b0, STAT_INACTIVE},
    '{OP_ADD_KEY,  8'd255, 4'd0,  1'b1, 1'b0, STAT_INACTIVE},
    '{OP_QUERY,    8'd0,   4'd0,  1'b1, 1'b1, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd255, 4'd3,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_QUERY,    8'd0,   4'd0,  1'b1, 1'b1, STAT_ACTIVE},
    '{OP_ADD_KEY,  8'd128, 4'd15, 1'b1, 1'b0, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd128, 4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_KEY_UP,   8'd0,   4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd0,   4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd0,   4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_ADD_KEY,  8'd64,  4'd0,  1'b1, 1'b0, STAT_INACTIVE},
    '{OP_QUERY,    8'd0,   4'd0,  1'b1, 1'b1, STAT_INACTIVE},
    '{OP_KEY_UP,   8'd64,  4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_CLEAR,    8'd0,   4'd15, 1'b1, 1'b0, STAT_INACTIVE},
    '{OP_QUERY,    8'd0,   4'd15, 1'b1, 1'b1, STAT_UNREG},
    '{OP_RSVD6,    8'd170, 4'd10, 1'b1, 1'b0, STAT_INACTIVE},
    '{OP_KEY_UP,   8'd255, 4'd0,  1'b0, 1'b0, STAT_INACTIVE},
    '{OP_KEY_DOWN, 8'd64,  4'd0,  1'b0, 1'b0, STAT_INACTIVE}
  };

  key_chord_detector #(
    .NUM_SLOTS(NUM_SLOTS),
    .KEY_CODES(KEY_CODES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // opcode, key_code, slot, pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // event_res, slot_out, status
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still outstanding", $time, pending_reports.size());
      $display("tb_key_chord_detector: FAIL");
      $finish;
    end
  end

  // Add one report to the current command's batch; extras past the limit are dropped
  task automatic append_report(input report_t rep);
    if (chord_batch.size() < MAX_RESULTS)
      chord_batch.insert(chord_batch.size(), rep);
  endtask

  // Apply one command to the shadow table; reports land in chord_batch
  task automatic predict_chord_reports(input logic [2:0] op, input logic [7:0] key,
                                       input logic [3:0] slot);
    kcd_stat_t st;
    chord_batch.delete();
    case (op)
      OP_KEY_DOWN: begin
        keys_down[key] = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_used[s] && !slot_live[s] && ((chord_mask[s] & ~keys_down) == '0)) begin
            slot_live[s] = 1'b1;
            append_report('{EV_ACTIVATED, 4'(s), STAT_INACTIVE, 1'b0});
          end
        end
      end
      OP_KEY_UP: begin
        keys_down[key] = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_live[s] && chord_mask[s][key]) begin
            slot_live[s] = 1'b0;
            append_report('{EV_DEACTIVATED, 4'(s), STAT_INACTIVE, 1'b0});
          end
        end
      end
      OP_CLEAR: begin
        chord_mask[slot] = '0;
        slot_used[slot]  = 1'b0;
        slot_live[slot]  = 1'b0;
      end
      OP_ADD_KEY: begin
        chord_mask[slot][key] = 1'b1;
        slot_used[slot]       = 1'b1;
        slot_live[slot]       = 1'b0;
      end
      OP_QUERY: begin
        if (!slot_used[slot])
          st = STAT_UNREG;
        else if (slot_live[slot])
          st = STAT_ACTIVE;
        else
          st = STAT_INACTIVE;
        append_report('{EV_REPLY, slot, st, 1'b0});
      end
      default: ;
    endcase
    if (chord_batch.size() > 0)
      chord_batch[chord_batch.size()-1].last = 1'b1;
  endtask

  // Offer one command; on acceptance, queue what it should report
  task automatic issue_row(input cmd_row_t row);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row.slot, row.key, row.op};
    do @(posedge clk); while (!s_tready);
    predict_chord_reports(row.op, row.key, row.slot);
    if (row.typed) begin
      chord_batch.delete();
      if (row.has_reply)
        append_report('{EV_REPLY, row.slot, row.stat, 1'b1});
    end
    foreach (chord_batch[i])
      pending_reports.insert(pending_reports.size(), chord_batch[i]);
    cmds_sent++;
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] key, input logic [3:0] slot);
    issue_row('{op, key, slot, 1'b0, 1'b0, STAT_INACTIVE});
  endtask

  // Hold the sender off until every queued report has come out
  task automatic drain_reports();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic refresh_pool();
    foreach (key_pool[i])
      key_pool[i] = 8'($urandom_range(0, 255));
  endtask

  // Same key in every slot, then press and release it: a full set of reports each way
  task automatic burst_all_slots(input logic [7:0] key);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      issue(OP_CLEAR, 8'($urandom_range(0, 255)), 4'(s));
      issue(OP_ADD_KEY, key, 4'(s));
    end
    issue(OP_KEY_DOWN, key, 4'($urandom_range(0, 15)));
    issue(OP_KEY_UP, key, 4'($urandom_range(0, 15)));
  endtask

  // Build a chord in one slot, press it, check it, break it
  task automatic chord_sequence();
    logic [7:0] chord [3];
    logic [3:0] s;
    int         n;
    s = 4'($urandom_range(0, 15));
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      chord[i] = key_pool[$urandom_range(0, 7)];
    issue(OP_CLEAR, 8'($urandom_range(0, 255)), s);
    for (int i = 0; i < n; i++)
      issue(OP_ADD_KEY, chord[i], s);
    if ($urandom_range(0, 1))
      issue(OP_QUERY, 8'($urandom_range(0, 255)), s);
    for (int i = n - 1; i >= 0; i--)
      issue(OP_KEY_DOWN, chord[i], 4'($urandom_range(0, 15)));
    issue(OP_QUERY, 8'($urandom_range(0, 255)), s);
    issue(OP_KEY_UP, chord[$urandom_range(0, n - 1)], 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 1))
      issue(OP_QUERY, 8'($urandom_range(0, 255)), s);
  endtask

  // Receiver backpressure
  always @(posedge clk)
    m_tready <= calm || ($urandom_range(0, 99) >= 36);

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Report checker
  always @(posedge clk) begin
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("event_res", want.ev, m_tdata[1:0]);
        check_field("slot_out", want.slot, m_tdata[5:2]);
        check_field("status", want.stat, m_tdata[7:6]);
        check_field("last", want.last, m_tlast);
        case (want.ev)
          EV_ACTIVATED:   n_act++;
          EV_DEACTIVATED: n_deact++;
          default:        n_reply++;
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    int base;
    int pick;
    logic [2:0] op;
    logic [7:0] key;

    keys_down = '0;
    slot_used = '0;
    slot_live = '0;
    foreach (chord_mask[i])
      chord_mask[i] = '0;
    refresh_pool();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed[i])
      issue_row(directed[i]);

    drain_reports();

    // random part
    base = cmds_sent;
    burst_all_slots(key_pool[0]);
    while (cmds_sent - base < RAND_CMDS) begin
      calm = (cmds_sent - base >= 100) && (cmds_sent - base < 180);
      if (cmds_sent - base >= 180 && cmds_sent - base < 190)
        drain_reports();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        chord_sequence();
      end else if (pick < 53) begin
        burst_all_slots(key_pool[$urandom_range(0, 7)]);
      end else if (pick < 60) begin
        refresh_pool();
      end else begin
        op  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : key_pool[$urandom_range(0, 7)];
        issue(op, key, 4'($urandom_range(0, 15)));
      end
    end
    calm = 1'b0;

    // wind down
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands; checked %0d activations, %0d deactivations, %0d query replies.",
             cmds_sent, n_act, n_deact, n_reply);
    if (errors == 0) begin
      $display("tb_key_chord_detector: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_key_chord_detector: FAIL");
    end
    $finish;
  end

endmodule
